### src/rot_pkg.sv
// Package for the image rotation unit: sizes, codes, payload structs and the
// sine and cosine tables built at elaboration. No dependencies.
package rot_pkg;

   // Source image limits and fixed-point format.
   localparam int MAX_SRC_WIDTH  = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int TRIG_FRAC_BITS = 14;

   localparam int COL_BITS   = $clog2(MAX_SRC_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_SRC_HEIGHT);
   localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
   localparam int PIXEL_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

   // Fixed field widths.
   localparam int CSR_BITS    = 9;
   localparam int CSR_IDX_BITS = 2;
   localparam int ANGLE_BITS  = 9;
   localparam int POS_IN_BITS = 9;
   localparam int COLOR_BITS  = 8;
   localparam int SIZE_BITS   = 10;
   localparam int SIZE_MAX    = 1023;
   localparam int MAX_ANGLE   = 360;
   localparam int WHITE       = 255;

   // Clamped source dimensions hold up to the larger maximum.
   localparam int MAX_DIM    = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH
                                                                : MAX_SRC_HEIGHT;
   localparam int DIM_RAW    = $clog2(MAX_DIM + 1);
   localparam int CLAMP_BITS = (DIM_RAW > CSR_BITS) ? DIM_RAW : CSR_BITS;

   // Arithmetic widths of the corner math and the inverse mapping.
   localparam int TRIG_BITS   = TRIG_FRAC_BITS + 2;
   localparam int PROD_BITS   = CLAMP_BITS + 1 + TRIG_BITS;
   localparam int CORNER_BITS = PROD_BITS + 1;
   localparam int SPAN_BITS   = CORNER_BITS + 1;
   localparam int XPOS_BITS   = POS_IN_BITS + TRIG_FRAC_BITS + 1;
   localparam int POS_BITS    = ((CORNER_BITS > XPOS_BITS) ? CORNER_BITS : XPOS_BITS) + 1;
   localparam int MUL_BITS    = POS_BITS + TRIG_BITS;
   localparam int SUM_BITS    = MUL_BITS + 1;
   localparam int QUO_BITS    = SUM_BITS - 2 * TRIG_FRAC_BITS;

   // Queue depths.
   localparam int CMD_DEPTH     = 4;
   localparam int CMD_PTR_BITS  = $clog2(CMD_DEPTH);
   localparam int OUT_DEPTH     = 8;
   localparam int OUT_PTR_BITS  = $clog2(OUT_DEPTH);
   localparam int SETTLE_CYCLES = 8;
   localparam int SETTLE_BITS   = $clog2(SETTLE_CYCLES + 1);

   // Register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_ANGLE  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEIGHT = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_ANGLE = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // Request type codes.
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_ANGLE = 2'd2,
      KIND_RANGE = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      logic                   req_type;
      logic [COLOR_BITS-1:0]  load_col;
      logic [COLOR_BITS-1:0]  load_row;
      logic [POS_IN_BITS-1:0] dest_x;
      logic [POS_IN_BITS-1:0] dest_y;
      logic [COLOR_BITS-1:0]  red_in;
      logic [COLOR_BITS-1:0]  green_in;
      logic [COLOR_BITS-1:0]  blue_in;
   } req_item_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] red_out;
      logic [COLOR_BITS-1:0] green_out;
      logic [COLOR_BITS-1:0] blue_out;
      logic                  is_fill;
      logic [SIZE_BITS-1:0]  rotated_width;
      logic [SIZE_BITS-1:0]  rotated_height;
      logic [1:0]            status;
   } rsp_item_type;

   // Classified item passed from the front to the back.
   typedef struct packed {
      cmd_kind_type            kind;
      logic [ADDR_BITS-1:0]    addr;
      logic [POS_IN_BITS-1:0]  x;
      logic [POS_IN_BITS-1:0]  y;
      logic [3*COLOR_BITS-1:0] rgb;
   } cmd_type;

   // Geometry derived from the registers.
   typedef struct packed {
      logic                          ok;
      logic signed [TRIG_BITS-1:0]   cos_value;
      logic signed [TRIG_BITS-1:0]   sin_value;
      logic signed [CORNER_BITS-1:0] offset_x;
      logic signed [CORNER_BITS-1:0] offset_y;
      logic [SIZE_BITS-1:0]          dest_w;
      logic [SIZE_BITS-1:0]          dest_h;
      logic [CLAMP_BITS-1:0]         src_w;
      logic [CLAMP_BITS-1:0]         src_h;
   } geom_type;

   typedef logic [TRIG_BITS-1:0] trig_word_type;
   typedef trig_word_type [MAX_ANGLE:0] trig_table_type;

   // Restoring long division, used only while the tables are built.
   function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
      logic [64:0]     rem;
      longint unsigned q;
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], a[i]};
         if (rem >= {1'b0, b}) begin
            rem  = rem - {1'b0, b};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // Taylor series of sine or cosine in t = a*3927/225000, magnitudes in Q32,
   // rounded half away from zero to the table format.
   function automatic trig_word_type trig_series(int unsigned a, bit odd);
      longint unsigned num;
      longint unsigned den;
      longint unsigned mag;
      longint unsigned n;
      longint unsigned v;
      longint unsigned r;
      longint          sum;
      bit              neg;
      int              sh;
      num = longint'(a) * 64'd3927;
      den = 64'd225000;
      mag = odd ? udiv64(num << 32, den) : (64'd1 << 32);
      n   = odd ? 64'd1 : 64'd0;
      sum = longint'(mag);
      neg = 1'b1;
      sh  = 32 - TRIG_FRAC_BITS;
      for (int k = 0; k < 40; k++) begin
         mag = udiv64(mag * num, den);
         mag = udiv64(mag * num, den);
         mag = udiv64(mag, (n + 64'd1) * (n + 64'd2));
         n   = n + 64'd2;
         if (neg) begin
            sum = sum - longint'(mag);
         end else begin
            sum = sum + longint'(mag);
         end
         neg = !neg;
      end
      v = (sum < 0) ? longint'(-sum) : longint'(sum);
      r = (v + (64'd1 << (sh - 1))) >> sh;
      return (sum < 0) ? trig_word_type'(-r) : trig_word_type'(r);
   endfunction

   function automatic trig_table_type build_trig_table(bit odd);
      trig_table_type t;
      for (int a = 0; a <= MAX_ANGLE; a++) begin
         t[a] = trig_series(a, odd);
      end
      return t;
   endfunction

   localparam trig_table_type COS_TABLE = build_trig_table(1'b0);
   localparam trig_table_type SIN_TABLE = build_trig_table(1'b1);

endpackage

### src/image_rotate_nearest_unit.sv
// Top level of the nearest-neighbor image rotation unit.
// Depends on rot_pkg, rot_front, rot_cmd_queue and rot_back.
//
// Usage: the request channel (req_valid, req_ready, req_data) carries load
// beats, which store one source pixel and give no result, and read beats,
// which give exactly one result beat on the response channel (rsp_valid,
// rsp_ready, rsp_data) in request order. The register port (csr_write,
// csr_index, csr_wdata) sets the angle, source width and source height.
// Throughput is one beat per cycle while req_ready is high; rsp_valid for a
// read rises after the read passes the command queue, the five-stage mapping
// pipeline with the registered pixel memory read in its last stage, and the
// write into the result queue.
// After reset and after every register write req_ready is low while the
// geometry pipeline settles. The back part reads the geometry live, so the
// user must write registers only while no beat is in flight; not enforced.
// When the receiver stalls, up to eight results wait in the result queue and
// the four-entry command queue fills before req_ready drops. The pixel memory
// is not cleared at reset.
module image_rotate_nearest_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rot_pkg::req_item_type            req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rot_pkg::rsp_item_type            rsp_data,
   input  logic                             csr_write,
   input  logic [rot_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [rot_pkg::CSR_BITS-1:0]     csr_wdata
);

   rot_pkg::geom_type geom;
   rot_pkg::cmd_type  push_data, pop_data;
   logic              push, pop, full, empty;

   rot_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (full),
      .q_push    (push),
      .q_data    (push_data),
      .geom      (geom)
   );

   rot_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   rot_back u_back (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom),
      .q_empty   (empty),
      .q_data    (pop_data),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### src/rot_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rot_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/rot_front.sv
// Front part of the rotation unit: registers, geometry derivation and
// classification of request beats. Depends on rot_pkg.
module rot_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [rot_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [rot_pkg::CSR_BITS-1:0]  csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rot_pkg::req_item_type         req_data,
   input  logic                          q_full,
   output logic                          q_push,
   output rot_pkg::cmd_type              q_data,
   output rot_pkg::geom_type             geom
);

   localparam int F = rot_pkg::TRIG_FRAC_BITS;
   localparam int CB = rot_pkg::CORNER_BITS;
   localparam int SB = rot_pkg::SPAN_BITS;

   logic [rot_pkg::ANGLE_BITS-1:0]  angle_ff, angle_in;
   logic [rot_pkg::CSR_BITS-1:0]    width_ff, width_in;
   logic [rot_pkg::CSR_BITS-1:0]    height_ff, height_in;
   logic [rot_pkg::SETTLE_BITS-1:0] settle_ff, settle_in;

   logic                                    ok1_ff, ok1_in;
   logic signed [rot_pkg::TRIG_BITS-1:0]    cos1_ff, cos1_in, sin1_ff, sin1_in;
   logic [rot_pkg::CLAMP_BITS-1:0]          w1_ff, w1_in, h1_ff, h1_in;
   logic signed [rot_pkg::PROD_BITS-1:0]    wc_ff, ws_ff, hc_ff, hs_ff;
   logic signed [rot_pkg::PROD_BITS-1:0]    wc_in, ws_in, hc_in, hs_in;
   logic signed [CB-1:0] p1x_ff, p1y_ff, p2x_ff, p2y_ff, p3x_ff, p3y_ff;
   logic signed [CB-1:0] p1x_in, p1y_in, p2x_in, p2y_in, p3x_in, p3y_in;
   logic signed [CB-1:0] mnx_ff, mny_ff, mxx_ff, mxy_ff;
   logic signed [CB-1:0] mnx_in, mny_in, mxx_in, mxy_in;
   logic [SB-1:0]        spanx_ff, spany_ff, spanx_in, spany_in;
   logic [rot_pkg::SIZE_BITS-1:0] dw_ff, dh_ff, dw_in, dh_in;

   logic [rot_pkg::CLAMP_BITS-1:0] width_ext, height_ext;
   logic [rot_pkg::ANGLE_BITS-1:0] angle_idx;
   logic                           is_read;
   logic                           load_inside;
   logic                           accept;

   function automatic logic signed [CB-1:0] min2(logic signed [CB-1:0] a,
                                                 logic signed [CB-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic signed [CB-1:0] max2(logic signed [CB-1:0] a,
                                                 logic signed [CB-1:0] b);
      return (a > b) ? a : b;
   endfunction

   // Rounds a span up to whole pixels and saturates it.
   function automatic logic [rot_pkg::SIZE_BITS-1:0] ceil_size(logic [SB-1:0] span);
      logic [SB:0] up;
      up = ({1'b0, span} + (SB+1)'((1 << F) - 1)) >> F;
      return (up > (SB+1)'(rot_pkg::SIZE_MAX)) ? rot_pkg::SIZE_BITS'(rot_pkg::SIZE_MAX)
                                                : up[rot_pkg::SIZE_BITS-1:0];
   endfunction

   // Register writes; every write restarts the settle count.
   always_comb begin
      angle_in  = angle_ff;
      width_in  = width_ff;
      height_in = height_ff;
      settle_in = (settle_ff != '0) ? settle_ff - 1'b1 : settle_ff;
      if (csr_write) begin
         settle_in = rot_pkg::SETTLE_BITS'(rot_pkg::SETTLE_CYCLES);
         unique case (csr_index)
            rot_pkg::CSR_ANGLE:  angle_in  = csr_wdata;
            rot_pkg::CSR_WIDTH:  width_in  = csr_wdata;
            rot_pkg::CSR_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff  <= '0;
         width_ff  <= rot_pkg::CSR_BITS'(256);
         height_ff <= rot_pkg::CSR_BITS'(256);
         settle_ff <= rot_pkg::SETTLE_BITS'(rot_pkg::SETTLE_CYCLES);
      end else begin
         angle_ff  <= angle_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         settle_ff <= settle_in;
      end
   end

   // Stage one: table lookup and clamped source size.
   always_comb begin
      width_ext  = rot_pkg::CLAMP_BITS'(width_ff);
      height_ext = rot_pkg::CLAMP_BITS'(height_ff);
      ok1_in     = (angle_ff <= rot_pkg::ANGLE_BITS'(rot_pkg::MAX_ANGLE));
      angle_idx  = ok1_in ? angle_ff : '0;
      cos1_in    = ok1_in ? rot_pkg::COS_TABLE[angle_idx] : '0;
      sin1_in    = ok1_in ? rot_pkg::SIN_TABLE[angle_idx] : '0;
      if (width_ext == '0) begin
         w1_in = rot_pkg::CLAMP_BITS'(1);
      end else if (width_ext > rot_pkg::CLAMP_BITS'(rot_pkg::MAX_SRC_WIDTH)) begin
         w1_in = rot_pkg::CLAMP_BITS'(rot_pkg::MAX_SRC_WIDTH);
      end else begin
         w1_in = width_ext;
      end
      if (height_ext == '0) begin
         h1_in = rot_pkg::CLAMP_BITS'(1);
      end else if (height_ext > rot_pkg::CLAMP_BITS'(rot_pkg::MAX_SRC_HEIGHT)) begin
         h1_in = rot_pkg::CLAMP_BITS'(rot_pkg::MAX_SRC_HEIGHT);
      end else begin
         h1_in = height_ext;
      end
   end

   // Stage two: the four size-by-trig products.
   always_comb begin
      wc_in = $signed({1'b0, w1_ff}) * cos1_ff;
      ws_in = $signed({1'b0, w1_ff}) * sin1_ff;
      hc_in = $signed({1'b0, h1_ff}) * cos1_ff;
      hs_in = $signed({1'b0, h1_ff}) * sin1_ff;
   end

   // Stage three: the rotated corners.
   always_comb begin
      p1x_in = -CB'(hs_ff);
      p1y_in = CB'(hc_ff);
      p2x_in = CB'(wc_ff) - CB'(hs_ff);
      p2y_in = CB'(hc_ff) + CB'(ws_ff);
      p3x_in = CB'(wc_ff);
      p3y_in = CB'(ws_ff);
   end

   // Stage four: minimum with the origin and maximum of the corners.
   always_comb begin
      mnx_in = min2('0, min2(p1x_ff, min2(p2x_ff, p3x_ff)));
      mny_in = min2('0, min2(p1y_ff, min2(p2y_ff, p3y_ff)));
      mxx_in = max2(p1x_ff, max2(p2x_ff, p3x_ff));
      mxy_in = max2(p1y_ff, max2(p2y_ff, p3y_ff));
   end

   // Stage five: spans from the absolute maximum; stage six: sizes.
   always_comb begin
      spanx_in = ((mxx_ff < 0) ? -SB'(mxx_ff) : SB'(mxx_ff)) - SB'(mnx_ff);
      spany_in = ((mxy_ff < 0) ? -SB'(mxy_ff) : SB'(mxy_ff)) - SB'(mny_ff);
      dw_in    = ok1_ff ? ceil_size(spanx_ff) : '0;
      dh_in    = ok1_ff ? ceil_size(spany_ff) : '0;
   end

   always_ff @(posedge clock) begin
      ok1_ff   <= ok1_in;
      cos1_ff  <= cos1_in;
      sin1_ff  <= sin1_in;
      w1_ff    <= w1_in;
      h1_ff    <= h1_in;
      wc_ff    <= wc_in;
      ws_ff    <= ws_in;
      hc_ff    <= hc_in;
      hs_ff    <= hs_in;
      p1x_ff   <= p1x_in;
      p1y_ff   <= p1y_in;
      p2x_ff   <= p2x_in;
      p2y_ff   <= p2y_in;
      p3x_ff   <= p3x_in;
      p3y_ff   <= p3y_in;
      mnx_ff   <= mnx_in;
      mny_ff   <= mny_in;
      mxx_ff   <= mxx_in;
      mxy_ff   <= mxy_in;
      spanx_ff <= spanx_in;
      spany_ff <= spany_in;
      dw_ff    <= dw_in;
      dh_ff    <= dh_in;
   end

   always_comb begin
      geom.ok        = ok1_ff;
      geom.cos_value = cos1_ff;
      geom.sin_value = sin1_ff;
      geom.offset_x  = ok1_ff ? mnx_ff : '0;
      geom.offset_y  = ok1_ff ? mny_ff : '0;
      geom.dest_w    = dw_ff;
      geom.dest_h    = dh_ff;
      geom.src_w     = w1_ff;
      geom.src_h     = h1_ff;
   end

   // Classify each request beat; loads outside the source are dropped here.
   always_comb begin
      req_ready   = (settle_ff == '0) && !q_full;
      accept      = req_valid && req_ready;
      is_read     = (req_data.req_type == rot_pkg::REQ_READ);
      load_inside = (rot_pkg::CLAMP_BITS'(req_data.load_col) < w1_ff) &&
                    (rot_pkg::CLAMP_BITS'(req_data.load_row) < h1_ff);
      q_push      = accept && (is_read || load_inside);
      q_data.addr = {rot_pkg::ROW_BITS'(req_data.load_row),
                     rot_pkg::COL_BITS'(req_data.load_col)};
      q_data.x    = req_data.dest_x;
      q_data.y    = req_data.dest_y;
      q_data.rgb  = {req_data.red_in, req_data.green_in, req_data.blue_in};
      if (!is_read) begin
         q_data.kind = rot_pkg::KIND_LOAD;
      end else if (!ok1_ff) begin
         q_data.kind = rot_pkg::KIND_ANGLE;
      end else if ((rot_pkg::SIZE_BITS'(req_data.dest_x) >= dw_ff) ||
                   (rot_pkg::SIZE_BITS'(req_data.dest_y) >= dh_ff)) begin
         q_data.kind = rot_pkg::KIND_RANGE;
      end else begin
         q_data.kind = rot_pkg::KIND_READ;
      end
   end

   // No beat is taken while the geometry is still settling.
   a_no_accept_settling: assert property (@(posedge clock) disable iff (reset)
      (settle_ff != '0) |-> !q_push)
      else $error("request accepted while geometry settles");

   // A register write always holds off the request channel on the next cycle.
   a_write_stalls: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> !req_ready)
      else $error("request channel ready right after a register write");

endmodule

### src/rot_cmd_queue.sv
// Short queue of classified items between the front and the back.
// Depends on rot_pkg.
module rot_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rot_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output rot_pkg::cmd_type pop_data,
   output logic             empty
);

   rot_pkg::cmd_type mem_ff [rot_pkg::CMD_DEPTH];
   logic [rot_pkg::CMD_PTR_BITS-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [rot_pkg::CMD_PTR_BITS:0]   count_ff, count_in;

   assign full     = (count_ff == (rot_pkg::CMD_PTR_BITS+1)'(rot_pkg::CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[head_ff];

   // Pointer and count update.
   always_comb begin
      head_in  = pop ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff + (rot_pkg::CMD_PTR_BITS+1)'(push) -
                 (rot_pkg::CMD_PTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[tail_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command queue underflow");

endmodule

### src/rot_back.sv
// Back part of the rotation unit: inverse mapping pipeline, source pixel
// memory and result queue. Depends on rot_pkg and rot_ram.
module rot_back (
   input  logic                  clock,
   input  logic                  reset,
   input  rot_pkg::geom_type     geom,
   input  logic                  q_empty,
   input  rot_pkg::cmd_type      q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rot_pkg::rsp_item_type rsp_data
);

   localparam int F   = rot_pkg::TRIG_FRAC_BITS;
   localparam int PB  = rot_pkg::POS_BITS;
   localparam int MB  = rot_pkg::MUL_BITS;
   localparam int SUB = rot_pkg::SUM_BITS;
   localparam int QB  = rot_pkg::QUO_BITS;
   localparam int CW  = rot_pkg::COLOR_BITS;

   rot_pkg::cmd_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [PB-1:0]  fx_ff, fy_ff, fx_in, fy_in;
   logic signed [MB-1:0]  pxc_ff, pys_ff, pyc_ff, pxs_ff;
   logic signed [SUB-1:0] sumx_ff, sumy_ff, sumx_in, sumy_in;
   logic signed [QB-1:0]  sx_ff, sy_ff, sx_in, sy_in;
   logic                  inside_ff, inside_in;
   logic signed [SUB-1:0] biasx, biasy, qx, qy;

   logic [3*CW-1:0]                    pix_rdata;
   logic [rot_pkg::ADDR_BITS-1:0]      rd_addr;
   logic                               wr_en;

   rot_pkg::rsp_item_type              out_mem_ff [rot_pkg::OUT_DEPTH];
   rot_pkg::rsp_item_type              res;
   logic [rot_pkg::OUT_PTR_BITS-1:0]   ohead_ff, ohead_in, otail_ff, otail_in;
   logic [rot_pkg::OUT_PTR_BITS:0]     ocount_ff, ocount_in;
   logic [rot_pkg::OUT_PTR_BITS:0]     inflight;
   logic                               opush, opop;

   // Pop only when a result slot is sure to be free for every item in flight.
   always_comb begin
      inflight = (rot_pkg::OUT_PTR_BITS+1)'($countones({v1_ff, v2_ff, v3_ff, v4_ff, v5_ff}));
      q_pop    = !q_empty && ((ocount_ff + inflight) <
                              (rot_pkg::OUT_PTR_BITS+1)'(rot_pkg::OUT_DEPTH));
   end

   // Stage one: destination point moved by the offset.
   always_comb begin
      fx_in = $signed({{(PB-rot_pkg::POS_IN_BITS-F){1'b0}}, q_data.x, {F{1'b0}}}) +
              PB'(geom.offset_x);
      fy_in = $signed({{(PB-rot_pkg::POS_IN_BITS-F){1'b0}}, q_data.y, {F{1'b0}}}) +
              PB'(geom.offset_y);
   end

   // Stage three: rotated sums; stage four: truncation toward zero and bounds.
   always_comb begin
      sumx_in   = SUB'(pxc_ff) + SUB'(pys_ff);
      sumy_in   = SUB'(pyc_ff) - SUB'(pxs_ff);
      biasx     = (sumx_ff < 0) ? $signed({{(SUB-2*F){1'b0}}, {(2*F){1'b1}}}) : '0;
      biasy     = (sumy_ff < 0) ? $signed({{(SUB-2*F){1'b0}}, {(2*F){1'b1}}}) : '0;
      qx        = (sumx_ff + biasx) >>> (2 * F);
      qy        = (sumy_ff + biasy) >>> (2 * F);
      sx_in     = qx[QB-1:0];
      sy_in     = qy[QB-1:0];
      inside_in = (sx_in >= 0) && (sx_in < $signed(QB'(geom.src_w))) &&
                  (sy_in >= 0) && (sy_in < $signed(QB'(geom.src_h)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= q_pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      c1_ff     <= q_data;
      fx_ff     <= fx_in;
      fy_ff     <= fy_in;
      c2_ff     <= c1_ff;
      pxc_ff    <= fx_ff * geom.cos_value;
      pys_ff    <= fy_ff * geom.sin_value;
      pyc_ff    <= fy_ff * geom.cos_value;
      pxs_ff    <= fx_ff * geom.sin_value;
      c3_ff     <= c2_ff;
      sumx_ff   <= sumx_in;
      sumy_ff   <= sumy_in;
      c4_ff     <= c3_ff;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      inside_ff <= inside_in;
      c5_ff     <= c4_ff;
   end

   // Loads write and reads look up the pixel memory at stage four, in order.
   assign wr_en   = v4_ff && (c4_ff.kind == rot_pkg::KIND_LOAD);
   assign rd_addr = {sy_ff[rot_pkg::ROW_BITS-1:0], sx_ff[rot_pkg::COL_BITS-1:0]};

   logic inside5_ff;
   always_ff @(posedge clock) begin
      inside5_ff <= inside_ff;
   end

   rot_ram #(
      .WIDTH(3 * CW),
      .DEPTH(rot_pkg::PIXEL_DEPTH)
   ) u_pixels (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (c4_ff.addr),
      .wr_data (c4_ff.rgb),
      .rd_addr (rd_addr),
      .rd_data (pix_rdata)
   );

   // Stage five: build the result beat.
   always_comb begin
      res = '0;
      unique case (c5_ff.kind)
         rot_pkg::KIND_ANGLE: begin
            res.status = rot_pkg::STATUS_ANGLE;
         end
         rot_pkg::KIND_RANGE: begin
            res.rotated_width  = geom.dest_w;
            res.rotated_height = geom.dest_h;
            res.status         = rot_pkg::STATUS_RANGE;
         end
         rot_pkg::KIND_READ: begin
            res.rotated_width  = geom.dest_w;
            res.rotated_height = geom.dest_h;
            res.status         = rot_pkg::STATUS_OK;
            if (inside5_ff) begin
               {res.red_out, res.green_out, res.blue_out} = pix_rdata;
            end else begin
               res.red_out   = CW'(rot_pkg::WHITE);
               res.green_out = CW'(rot_pkg::WHITE);
               res.blue_out  = CW'(rot_pkg::WHITE);
               res.is_fill   = 1'b1;
            end
         end
         rot_pkg::KIND_LOAD: ;
         default: ;
      endcase
      opush = v5_ff && (c5_ff.kind != rot_pkg::KIND_LOAD);
   end

   // Result queue, which also serves as the output register.
   always_comb begin
      rsp_valid = (ocount_ff != '0);
      rsp_data  = out_mem_ff[ohead_ff];
      opop      = rsp_valid && rsp_ready;
      ohead_in  = opop ? ohead_ff + 1'b1 : ohead_ff;
      otail_in  = opush ? otail_ff + 1'b1 : otail_ff;
      ocount_in = ocount_ff + (rot_pkg::OUT_PTR_BITS+1)'(opush) -
                  (rot_pkg::OUT_PTR_BITS+1)'(opop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ohead_ff  <= '0;
         otail_ff  <= '0;
         ocount_ff <= '0;
      end else begin
         ohead_ff  <= ohead_in;
         otail_ff  <= otail_in;
         ocount_ff <= ocount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (opush) begin
         out_mem_ff[otail_ff] <= res;
      end
   end

   // Reserved slots never exceed the result queue.
   a_credit: assert property (@(posedge clock) disable iff (reset)
      (ocount_ff + inflight) <= (rot_pkg::OUT_PTR_BITS+1)'(rot_pkg::OUT_DEPTH))
      else $error("result queue over-committed");

   // A load that writes the memory gives no result push when it reaches the next stage.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> !opush)
      else $error("load produced a result beat");

endmodule

### test/image_rotate_nearest_unit_tb.sv
// Testbench for image_rotate_nearest_unit: loads source pixels, reads rotated pixels
// and checks every response beat against a predictor kept in a scoreboard class.
// Depends on rot_pkg and the unit itself.
`timescale 1ns / 100ps

module image_rotate_nearest_unit_tb;
   import rot_pkg::*;

   // Holds the source image, the geometry and the responses still owed.
   class rotation_scoreboard;
      logic [23:0]  pixel_mem [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
      bit           pixel_loaded [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
      int           angle_reg = 0;
      int           width_reg = 256;
      int           height_reg = 256;
      bit           angle_ok;
      longint       cos_q, sin_q, org_x, org_y, dest_w, dest_h;
      rsp_item_type owed_pixels[$];
      int           errors = 0;

      function new();
         update_geometry();
      endfunction

      // Series sum of cosine or sine in Q32, rounded to Q14 half away from zero.
      function longint angle_trig(int unsigned deg, bit want_sine);
         longint unsigned num, den, term, order, mag_abs, rounded;
         longint          acc;
         bit              subtract;
         num = longint'(deg) * 3927;
         den = 225000;
         term = want_sine ? ((num << 32) / den) : (64'd1 << 32);
         order = want_sine ? 1 : 0;
         acc = longint'(term);
         subtract = 1'b1;
         for (int k = 0; k < 40; k++) begin
            term = term * num / den;
            term = term * num / den;
            term = term / ((order + 1) * (order + 2));
            order = order + 2;
            if (subtract) acc = acc - longint'(term);
            else acc = acc + longint'(term);
            subtract = !subtract;
         end
         mag_abs = (acc < 0) ? longint'(-acc) : longint'(acc);
         rounded = (mag_abs + (64'd1 << 17)) >> 18;
         return (acc < 0) ? -longint'(rounded) : longint'(rounded);
      endfunction

      function longint clamp_dim(int v);
         if (v < 1) return 1;
         if (v > 256) return 256;
         return v;
      endfunction

      function longint ceil_dim(longint span);
         longint s;
         s = (span + (64'sd1 << TRIG_FRAC_BITS) - 1) >>> TRIG_FRAC_BITS;
         return (s > SIZE_MAX) ? SIZE_MAX : s;
      endfunction

      // Rotated corners give the destination offset and size.
      function void update_geometry();
         longint w, h, ax, ay, bx, by, cx, cy, lo_x, lo_y, hi_x, hi_y;
         w = clamp_dim(width_reg);
         h = clamp_dim(height_reg);
         angle_ok = (angle_reg <= MAX_ANGLE);
         cos_q = 0; sin_q = 0; org_x = 0; org_y = 0; dest_w = 0; dest_h = 0;
         if (!angle_ok) return;
         cos_q = angle_trig(angle_reg, 1'b0);
         sin_q = angle_trig(angle_reg, 1'b1);
         ax = -h * sin_q;             ay = h * cos_q;
         bx = w * cos_q - h * sin_q;  by = h * cos_q + w * sin_q;
         cx = w * cos_q;              cy = w * sin_q;
         lo_x = 0; lo_y = 0;
         if (ax < lo_x) lo_x = ax;
         if (bx < lo_x) lo_x = bx;
         if (cx < lo_x) lo_x = cx;
         if (ay < lo_y) lo_y = ay;
         if (by < lo_y) lo_y = by;
         if (cy < lo_y) lo_y = cy;
         hi_x = ax; hi_y = ay;
         if (bx > hi_x) hi_x = bx;
         if (cx > hi_x) hi_x = cx;
         if (by > hi_y) hi_y = by;
         if (cy > hi_y) hi_y = cy;
         if (hi_x < 0) hi_x = -hi_x;
         if (hi_y < 0) hi_y = -hi_y;
         org_x = lo_x;
         org_y = lo_y;
         dest_w = ceil_dim(hi_x - lo_x);
         dest_h = ceil_dim(hi_y - lo_y);
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, int value);
         if (idx == CSR_ANGLE) angle_reg = value;
         else if (idx == CSR_WIDTH) width_reg = value;
         else if (idx == CSR_HEIGHT) height_reg = value;
         update_geometry();
      endfunction

      // Inverse mapping of one destination pixel; flags a hit on a never-loaded pixel.
      function rsp_item_type map_read(int x, int y, output bit unloaded);
         rsp_item_type r;
         longint fx, fy, sx, sy, w, h;
         int addr;
         r = '0;
         unloaded = 1'b0;
         if (!angle_ok) begin
            r.status = STATUS_ANGLE;
            return r;
         end
         r.rotated_width = dest_w[SIZE_BITS-1:0];
         r.rotated_height = dest_h[SIZE_BITS-1:0];
         if (x >= dest_w || y >= dest_h) begin
            r.status = STATUS_RANGE;
            return r;
         end
         r.status = STATUS_OK;
         w = clamp_dim(width_reg);
         h = clamp_dim(height_reg);
         fx = longint'(x) * (64'sd1 << TRIG_FRAC_BITS) + org_x;
         fy = longint'(y) * (64'sd1 << TRIG_FRAC_BITS) + org_y;
         sx = (fx * cos_q + fy * sin_q) / (64'sd1 << (2*TRIG_FRAC_BITS));
         sy = (fy * cos_q - fx * sin_q) / (64'sd1 << (2*TRIG_FRAC_BITS));
         if (sx >= 0 && sx < w && sy >= 0 && sy < h) begin
            addr = int'(sy) * MAX_SRC_WIDTH + int'(sx);
            unloaded = !pixel_loaded[addr];
            {r.red_out, r.green_out, r.blue_out} = pixel_mem[addr];
         end else begin
            r.red_out = COLOR_BITS'(WHITE);
            r.green_out = COLOR_BITS'(WHITE);
            r.blue_out = COLOR_BITS'(WHITE);
            r.is_fill = 1'b1;
         end
         return r;
      endfunction

      // Called for every accepted request beat.
      function void note_request(req_item_type q);
         bit unused;
         int addr;
         if (q.req_type == REQ_LOAD) begin
            if (q.load_col < clamp_dim(width_reg) && q.load_row < clamp_dim(height_reg)) begin
               addr = int'(q.load_row) * MAX_SRC_WIDTH + int'(q.load_col);
               pixel_mem[addr] = {q.red_in, q.green_in, q.blue_in};
               pixel_loaded[addr] = 1'b1;
            end
         end else begin
            owed_pixels.push_back(map_read(int'(q.dest_x), int'(q.dest_y), unused));
         end
      endfunction

      function void report_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      // Called for every accepted response beat.
      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (owed_pixels.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = owed_pixels.pop_front();
         report_field("red_out", int'(want.red_out), int'(got.red_out));
         report_field("green_out", int'(want.green_out), int'(got.green_out));
         report_field("blue_out", int'(want.blue_out), int'(got.blue_out));
         report_field("is_fill", int'(want.is_fill), int'(got.is_fill));
         report_field("rotated_width", int'(want.rotated_width), int'(got.rotated_width));
         report_field("rotated_height", int'(want.rotated_height),
                      int'(got.rotated_height));
         report_field("status", int'(want.status), int'(got.status));
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   req_item_type            req_data;
   logic                    rsp_valid;
   logic                    rsp_ready;
   rsp_item_type            rsp_data;
   logic                    csr_write;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_BITS-1:0]     csr_wdata;

   rotation_scoreboard board;
   bit                 idling_on;
   int                 items_sent;

   image_rotate_nearest_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sends one request beat, with random gaps ahead of it when idling is on.
   task automatic send_beat(req_item_type q);
      @(negedge clock);
      while (idling_on && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (!req_ready);
      board.note_request(q);
      items_sent++;
   endtask

   function automatic req_item_type random_beat();
      logic [63:0] raw;
      req_item_type q;
      raw = {$urandom, $urandom};
      q = raw[$bits(req_item_type)-1:0];
      return q;
   endfunction

   task automatic send_load(int col, int row, logic [23:0] rgb);
      req_item_type q;
      q = random_beat();
      q.req_type = REQ_LOAD;
      q.load_col = COLOR_BITS'(col);
      q.load_row = COLOR_BITS'(row);
      {q.red_in, q.green_in, q.blue_in} = rgb;
      send_beat(q);
   endtask

   task automatic send_read(int x, int y);
      req_item_type q;
      q = random_beat();
      q.req_type = REQ_READ;
      q.dest_x = POS_IN_BITS'(x);
      q.dest_y = POS_IN_BITS'(y);
      send_beat(q);
   endtask

   // Picks a destination pixel whose source is loaded, lies outside, or is off range.
   task automatic send_random_read();
      bit unloaded;
      rsp_item_type dummy;
      int x, y;
      for (int tries = 0; tries < 40; tries++) begin
         if ($urandom_range(0, 9) < 8) begin
            x = $urandom_range(0, int'(board.dest_w) + 1);
            y = $urandom_range(0, int'(board.dest_h) + 1);
         end else begin
            x = $urandom_range(0, 511);
            y = $urandom_range(0, 511);
         end
         if (x > 511) x = 511;
         if (y > 511) y = 511;
         dummy = board.map_read(x, y, unloaded);
         if (!unloaded) begin
            send_read(x, y);
            return;
         end
      end
      // The destination never reaches 511, so this read is always off range.
      send_read(511, 511);
   endtask

   // Waits until every owed response has come and the load pipeline has drained.
   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.owed_pixels.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, int value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_BITS'(value);
      @(posedge clock);
      board.write_reg(idx, value & 9'h1FF);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // One setting: registers, a source image, then reads mixed with a few loads.
   task automatic run_setting(int angle, int width, int height, int reads);
      int w, h, col, row;
      wait_quiet();
      write_reg(CSR_ANGLE, angle);
      write_reg(CSR_WIDTH, width);
      write_reg(CSR_HEIGHT, height);
      w = board.clamp_dim(width);
      h = board.clamp_dim(height);
      if (w * h <= 200) begin
         for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) send_load(c, r, 24'($urandom));
         end
      end else begin
         for (int k = 0; k < 80; k++) begin
            send_load($urandom_range(0, w - 1), $urandom_range(0, h - 1), 24'($urandom));
         end
      end
      for (int k = 0; k < reads; k++) begin
         if ($urandom_range(0, 9) < 2) begin
            // Loads that land outside the source image are dropped by the unit.
            col = $urandom_range(0, 255);
            row = $urandom_range(0, 255);
            if ($urandom_range(0, 1) == 0) begin
               col = $urandom_range(0, w - 1);
               row = $urandom_range(0, h - 1);
            end
            send_load(col, row, 24'($urandom));
         end
         send_random_read();
      end
   endtask

   // Response side: random stalls, checked at the rising edge.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= idling_on ? ($urandom_range(0, 99) >= 33) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int angle, width, height;
      board = new();
      idling_on = 1'b1;
      items_sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = CSR_ANGLE;
      csr_wdata = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed: corner pixels at the reset geometry, then extreme settings.
      send_load(0, 0, 24'h000000);
      send_load(255, 255, 24'hFFFFFF);
      send_load(255, 0, 24'hA5C3F0);
      send_load(0, 255, 24'h5A3C0F);
      send_read(0, 0);
      send_read(255, 255);
      send_read(255, 0);
      send_read(0, 255);
      send_read(256, 0);
      send_read(511, 511);
      run_setting(360, 0, 511, 4);
      run_setting(361, 3, 3, 3);
      run_setting(511, 256, 1, 3);
      run_setting(90, 1, 1, 3);
      run_setting(180, 4, 2, 3);
      run_setting(270, 2, 5, 3);
      run_setting(45, 256, 256, 4);

      // Random settings, mostly small images; one setting in four runs without idling.
      for (int setting = 0; items_sent < 1800; setting++) begin
         idling_on = (setting % 4) != 1;
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 5))
               0: angle = 0;
               1: angle = 90;
               2: angle = 180;
               3: angle = 270;
               4: angle = 360;
               default: angle = $urandom_range(361, 511);
            endcase
         end else begin
            angle = $urandom_range(0, 360);
         end
         if ($urandom_range(0, 99) < 15) begin
            width = $urandom_range(0, 511);
            height = $urandom_range(0, 511);
         end else begin
            width = $urandom_range(1, 14);
            height = $urandom_range(1, 14);
         end
         run_setting(angle, width, height, $urandom_range(20, 60));
      end

      wait_quiet();
      repeat (20) @(posedge clock);
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
